>>> hdl/sstc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstc_pkg
// Shared types and constants for the supply station tick controller.
// ----------------------------------------------------------------------------
package sstc_pkg;

    localparam int CMP_W   = 14;    // servo compare width
    localparam int NUM_CFG = 8;     // configuration registers
    localparam int CFG_IW  = 3;     // register index bits
    localparam int ADDR_W  = 5;     // byte address bits
    localparam int DATA_W  = 32;    // APB data width
    localparam int NUM_IR  = 4;     // IR lines per side
    localparam int NUM_SW  = 2;     // request switches / gates
    localparam int TOTAL_W = 32;    // supply counter width

    // Parameter defaults
    localparam int SENSOR_CONFIRM_TICKS_DEF = 3;
    localparam int PRESS_CONFIRM_TICKS_DEF  = 4;
    localparam int GATE_OPEN_TICKS_DEF      = 30;
    localparam int STIR_PERIOD_TICKS_DEF    = 40;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_GATE1_OPEN    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GATE1_CLOSED  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_GATE2_OPEN    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GATE2_CLOSED  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_HOPPER_OPEN   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_HOPPER_CLOSED = 3'd5;
    localparam logic [CFG_IW-1:0] REG_STIR_FIRST    = 3'd6;
    localparam logic [CFG_IW-1:0] REG_STIR_SECOND   = 3'd7;

    // Register reset values
    localparam logic [CMP_W-1:0] RST_GATE1_OPEN    = 14'd210;
    localparam logic [CMP_W-1:0] RST_GATE1_CLOSED  = 14'd400;
    localparam logic [CMP_W-1:0] RST_GATE2_OPEN    = 14'd350;
    localparam logic [CMP_W-1:0] RST_GATE2_CLOSED  = 14'd650;
    localparam logic [CMP_W-1:0] RST_HOPPER_OPEN   = 14'd250;
    localparam logic [CMP_W-1:0] RST_HOPPER_CLOSED = 14'd600;
    localparam logic [CMP_W-1:0] RST_STIR_FIRST    = 14'd300;
    localparam logic [CMP_W-1:0] RST_STIR_SECOND   = 14'd1000;

    typedef struct packed {
        logic [NUM_IR-1:0] outside_sensors;
        logic [NUM_IR-1:0] inside_sensors;
        logic [NUM_SW-1:0] switch_lines;
    } t_in_word;

    typedef struct packed {
        logic [CMP_W-1:0]   gate1_compare;
        logic [CMP_W-1:0]   gate2_compare;
        logic [CMP_W-1:0]   hopper_compare;
        logic [CMP_W-1:0]   stir_compare;
        logic [NUM_SW-1:0]  lamps;
        logic               outside_full;
        logic               inside_full;
        logic               container_select;
        logic [TOTAL_W-1:0] supply_count;
    } t_out_word;

endpackage

>>> hdl/supply_station_tick_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_station_tick_controller
// Per-tick IR presence qualifiers, request switch / gate sequencers, supply
// counter, hopper and stirring servo control, with an APB register file.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                        | word
//  ---------+-----------+----------------------------------+---------------------
//  tick in  | in        | i_in_valid / o_in_stall          | i_in_word  (t_in_word)
//  result   | out       | o_out_valid / i_out_stall        | o_out_word (t_out_word)
//  config   | in/out    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
//  Cycles: one tick word per clock while o_in_stall is low. All state is
//  registered in the accept cycle, and so is the result word.
//  Stalls: o_in_stall is high only while a result is held and the sink stalls;
//  a new tick is taken in the same cycle the held result leaves.
//  Reset: synchronous, active low; state cleared, registers to defaults.
//  No clearing pass after reset.
//
module supply_station_tick_controller #(
    parameter int SENSOR_CONFIRM_TICKS = sstc_pkg::SENSOR_CONFIRM_TICKS_DEF,
    parameter int PRESS_CONFIRM_TICKS  = sstc_pkg::PRESS_CONFIRM_TICKS_DEF,
    parameter int GATE_OPEN_TICKS      = sstc_pkg::GATE_OPEN_TICKS_DEF,
    parameter int STIR_PERIOD_TICKS    = sstc_pkg::STIR_PERIOD_TICKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tick input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sstc_pkg::t_in_word           i_in_word,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sstc_pkg::t_out_word          o_out_word,
    // APB config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sstc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sstc_pkg::DATA_W-1:0]  pwdata,
    output logic [sstc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    // Counter limits and widths, derived from the parameters and the package.
    localparam int GATE_CLOSE_AT = GATE_OPEN_TICKS + PRESS_CONFIRM_TICKS;
    localparam int GATE_CAP      = GATE_CLOSE_AT + 1;
    localparam int QW            = $clog2(SENSOR_CONFIRM_TICKS + 1);
    localparam int GW            = $clog2(GATE_CAP + 1);
    localparam int SW            = $clog2(STIR_PERIOD_TICKS + 1);
    localparam int NLINES        = 2 * sstc_pkg::NUM_IR;

    localparam logic [QW-1:0] Q_CONFIRM  = QW'(SENSOR_CONFIRM_TICKS);
    localparam logic [GW-1:0] G_PRESS    = GW'(PRESS_CONFIRM_TICKS);
    localparam logic [GW-1:0] G_CLOSE_AT = GW'(GATE_CLOSE_AT);
    localparam logic [GW-1:0] G_CAP      = GW'(GATE_CAP);
    localparam logic [SW-1:0] S_PERIOD   = SW'(STIR_PERIOD_TICKS);

    // ------------------------------------------------------------------
    // Handshake: single output register, refilled in the cycle it drains.
    // ------------------------------------------------------------------
    logic in_accept;
    logic cfg_wr;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [sstc_pkg::CMP_W-1:0]  r_cfg [sstc_pkg::NUM_CFG];
    logic [sstc_pkg::CFG_IW-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[sstc_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign prdata  = sstc_pkg::DATA_W'(r_cfg[cfg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[sstc_pkg::REG_GATE1_OPEN]    <= sstc_pkg::RST_GATE1_OPEN;
            r_cfg[sstc_pkg::REG_GATE1_CLOSED]  <= sstc_pkg::RST_GATE1_CLOSED;
            r_cfg[sstc_pkg::REG_GATE2_OPEN]    <= sstc_pkg::RST_GATE2_OPEN;
            r_cfg[sstc_pkg::REG_GATE2_CLOSED]  <= sstc_pkg::RST_GATE2_CLOSED;
            r_cfg[sstc_pkg::REG_HOPPER_OPEN]   <= sstc_pkg::RST_HOPPER_OPEN;
            r_cfg[sstc_pkg::REG_HOPPER_CLOSED] <= sstc_pkg::RST_HOPPER_CLOSED;
            r_cfg[sstc_pkg::REG_STIR_FIRST]    <= sstc_pkg::RST_STIR_FIRST;
            r_cfg[sstc_pkg::REG_STIR_SECOND]   <= sstc_pkg::RST_STIR_SECOND;
        end else if (cfg_wr) begin
            // upper data bits dropped
            r_cfg[cfg_idx] <= pwdata[sstc_pkg::CMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Tick state
    // ------------------------------------------------------------------
    logic [QW-1:0]                r_qcnt [NLINES];
    logic [NLINES-1:0]            r_present;
    logic [GW-1:0]                r_gcnt [sstc_pkg::NUM_SW];
    logic [sstc_pkg::NUM_SW-1:0]  r_gate_open;
    logic [SW-1:0]                r_stir_cnt;
    logic                         r_stir_phase;
    logic [sstc_pkg::TOTAL_W-1:0] r_total;

    logic [QW-1:0]                n_qcnt [NLINES];
    logic [NLINES-1:0]            n_present;
    logic [GW-1:0]                n_gcnt [sstc_pkg::NUM_SW];
    logic [sstc_pkg::NUM_SW-1:0]  n_gate_open;
    logic [SW-1:0]                n_stir_cnt;
    logic                         n_stir_phase;
    logic [sstc_pkg::TOTAL_W-1:0] n_total;

    logic [NLINES-1:0]            lines;
    logic [sstc_pkg::NUM_SW-1:0]  pressed;
    logic [sstc_pkg::NUM_SW-1:0]  supply_inc;
    logic                         out_full;
    logic                         in_full;
    logic                         both_full;
    logic [SW-1:0]                stir_inc;

    // lines 0..3 outside, 4..7 inside
    assign lines   = {i_in_word.inside_sensors, i_in_word.outside_sensors};
    assign pressed = ~i_in_word.switch_lines;   // switches are active low

    // IR qualifiers: first high level starts the count, which saturates at
    // the confirm value; from there the level itself sets or drops presence.
    always_comb begin
        logic [QW-1:0] c;
        for (int i = 0; i < NLINES; i++) begin
            c            = r_qcnt[i];
            n_qcnt[i]    = r_qcnt[i];
            n_present[i] = r_present[i];
            if (c == '0) begin
                if (lines[i]) begin
                    n_qcnt[i] = QW'(1);
                end
            end else begin
                if (c < Q_CONFIRM) begin
                    c = c + QW'(1);
                end
                n_qcnt[i] = c;
                if (c >= Q_CONFIRM) begin
                    if (lines[i]) begin
                        n_present[i] = 1'b1;
                    end else begin
                        n_present[i] = 1'b0;
                        n_qcnt[i]    = '0;
                    end
                end
            end
        end
    end

    // Switch sequencers. Count 1..PRESS is the debounce window; the step out
    // of PRESS either confirms (gate opens, one supply) or aborts. The gate
    // closes at CLOSE_AT; the count then sits until the switch is released.
    always_comb begin
        logic [GW-1:0] now;
        for (int i = 0; i < sstc_pkg::NUM_SW; i++) begin
            n_gcnt[i]      = r_gcnt[i];
            n_gate_open[i] = r_gate_open[i];
            supply_inc[i]  = 1'b0;
            now            = (r_gcnt[i] < G_CAP) ? r_gcnt[i] + GW'(1) : r_gcnt[i];
            if (r_gcnt[i] == '0) begin
                if (pressed[i]) begin
                    n_gcnt[i] = GW'(1);
                end
            end else begin
                n_gcnt[i] = now;
                if (r_gcnt[i] == G_PRESS) begin
                    if (pressed[i]) begin
                        supply_inc[i]  = 1'b1;
                        n_gate_open[i] = 1'b1;
                    end else begin
                        n_gcnt[i] = '0;
                    end
                end else if (now == G_CLOSE_AT) begin
                    n_gate_open[i] = 1'b0;
                end else if (!pressed[i] && now > G_CLOSE_AT) begin
                    n_gcnt[i] = '0;
                end
            end
        end
    end

    // both channels may confirm on the same tick
    assign n_total = r_total + sstc_pkg::TOTAL_W'(supply_inc[0])
                             + sstc_pkg::TOTAL_W'(supply_inc[1]);

    assign out_full  = |n_present[sstc_pkg::NUM_IR-1:0];
    assign in_full   = |n_present[NLINES-1:sstc_pkg::NUM_IR];
    assign both_full = out_full & in_full;

    // Stirring runs only while feeding (not both sides full).
    assign stir_inc = r_stir_cnt + SW'(1);

    always_comb begin
        n_stir_cnt   = r_stir_cnt;
        n_stir_phase = r_stir_phase;
        if (!both_full) begin
            if (stir_inc >= S_PERIOD) begin
                n_stir_cnt   = '0;
                n_stir_phase = ~r_stir_phase;
            end else begin
                n_stir_cnt   = stir_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NLINES; i++) begin
                r_qcnt[i] <= '0;
            end
            for (int i = 0; i < sstc_pkg::NUM_SW; i++) begin
                r_gcnt[i] <= '0;
            end
            r_present    <= '0;
            r_gate_open  <= '0;
            r_stir_cnt   <= '0;
            r_stir_phase <= 1'b0;
            r_total      <= '0;
        end else if (in_accept) begin
            r_qcnt       <= n_qcnt;
            r_gcnt       <= n_gcnt;
            r_present    <= n_present;
            r_gate_open  <= n_gate_open;
            r_stir_cnt   <= n_stir_cnt;
            r_stir_phase <= n_stir_phase;
            r_total      <= n_total;
        end
    end

    // ------------------------------------------------------------------
    // Result word, built from the post-tick state
    // ------------------------------------------------------------------
    sstc_pkg::t_out_word n_out;

    always_comb begin
        n_out.gate1_compare    = n_gate_open[0] ? r_cfg[sstc_pkg::REG_GATE1_OPEN]
                                                : r_cfg[sstc_pkg::REG_GATE1_CLOSED];
        n_out.gate2_compare    = n_gate_open[1] ? r_cfg[sstc_pkg::REG_GATE2_OPEN]
                                                : r_cfg[sstc_pkg::REG_GATE2_CLOSED];
        n_out.hopper_compare   = both_full ? r_cfg[sstc_pkg::REG_HOPPER_CLOSED]
                                           : r_cfg[sstc_pkg::REG_HOPPER_OPEN];
        n_out.stir_compare     = n_stir_phase ? r_cfg[sstc_pkg::REG_STIR_SECOND]
                                              : r_cfg[sstc_pkg::REG_STIR_FIRST];
        n_out.lamps            = n_gate_open;
        n_out.outside_full     = out_full;
        n_out.inside_full      = in_full;
        n_out.container_select = out_full;
        n_out.supply_count     = n_total;
    end

    logic                r_out_valid;
    sstc_pkg::t_out_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // a lit gate lies strictly inside its open window
    generate
        for (genvar g = 0; g < sstc_pkg::NUM_SW; g++) begin : g_gate_chk
            a_gate_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_gate_open[g] |-> (r_gcnt[g] > G_PRESS) && (r_gcnt[g] < G_CLOSE_AT))
                else $error("gate open outside its count window");
        end
        for (genvar l = 0; l < NLINES; l++) begin : g_ir_chk
            a_present_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_present[l] |-> (r_qcnt[l] == Q_CONFIRM))
                else $error("presence flag set without a qualified count");
        end
    endgenerate

    a_stir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stir_cnt < S_PERIOD)
        else $error("stir counter beyond its period");

    a_total_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_total))
        else $error("supply count moved without a tick");
`endif

endmodule

>>> dv/supply_station_tick_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_station_tick_controller_tb
// Self-checking bench for the supply station tick controller. Tick words
// come from a queue, built from a short directed list and then from random
// sensor and switch runs. A bench-side copy of the controller predicts every
// status word, and each status word is checked field by field. The servo
// compare registers are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module supply_station_tick_controller_tb;

    // Controller timing, taken from the default parameters of the block
    localparam int IR_CONFIRM    = sstc_pkg::SENSOR_CONFIRM_TICKS_DEF;
    localparam int PRESS_CONFIRM = sstc_pkg::PRESS_CONFIRM_TICKS_DEF;
    localparam int GATE_CLOSE_AT = sstc_pkg::GATE_OPEN_TICKS_DEF
                                 + sstc_pkg::PRESS_CONFIRM_TICKS_DEF;
    localparam int GATE_CAP      = GATE_CLOSE_AT + 1;
    localparam int STIR_PERIOD   = sstc_pkg::STIR_PERIOD_TICKS_DEF;

    localparam int CYCLE_LIMIT   = 200000;  // watchdog limit on the whole run
    localparam int LONG_HOLD     = 64;      // sink hold-off that backs up the block
    localparam int SETTLE_CYCLES = 8;       // wait after the last drain before the final check
    localparam int MAX_REPORTS   = 10;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    sstc_pkg::t_in_word            i_in_word  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    sstc_pkg::t_out_word           o_out_word;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [sstc_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [sstc_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [sstc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    supply_station_tick_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    sstc_pkg::t_in_word   tick_queue[$];        // tick words not yet offered
    sstc_pkg::t_out_word  expected_status[$];   // predicted status words, oldest first
    int         error_count    = 0;
    int         cycle_count    = 0;
    logic       idle_on        = 1'b1; // random gaps / stalls allowed
    logic       long_hold_req  = 1'b0; // ask the sink for one long hold-off
    logic       long_hold_done = 1'b0; // sink has served the request
    int         send_gap       = 0;
    int         stall_left     = 0;

    // Shadow of the controller: register file plus tick state
    logic [sstc_pkg::CMP_W-1:0]    cmp_shadow [sstc_pkg::NUM_CFG];
    logic [1:0]                    ir_count   [2*sstc_pkg::NUM_IR];
    logic [2*sstc_pkg::NUM_IR-1:0] ir_seen;
    logic [5:0]                    gate_steps [sstc_pkg::NUM_SW];
    logic [sstc_pkg::NUM_SW-1:0]   gate_open;
    logic [5:0]                    stir_ticks;
    logic                          stir_phase;
    logic [sstc_pkg::TOTAL_W-1:0]  supplies;

    // Random stimulus: each of the eight IR lines and two switches holds
    // its level for a run of ticks, so the qualifiers and the gate
    // sequencer actually get past their first steps.
    logic [9:0]         run_level;
    int                 run_left [10];

    task automatic clear_shadow();
        cmp_shadow[sstc_pkg::REG_GATE1_OPEN]    = sstc_pkg::RST_GATE1_OPEN;
        cmp_shadow[sstc_pkg::REG_GATE1_CLOSED]  = sstc_pkg::RST_GATE1_CLOSED;
        cmp_shadow[sstc_pkg::REG_GATE2_OPEN]    = sstc_pkg::RST_GATE2_OPEN;
        cmp_shadow[sstc_pkg::REG_GATE2_CLOSED]  = sstc_pkg::RST_GATE2_CLOSED;
        cmp_shadow[sstc_pkg::REG_HOPPER_OPEN]   = sstc_pkg::RST_HOPPER_OPEN;
        cmp_shadow[sstc_pkg::REG_HOPPER_CLOSED] = sstc_pkg::RST_HOPPER_CLOSED;
        cmp_shadow[sstc_pkg::REG_STIR_FIRST]    = sstc_pkg::RST_STIR_FIRST;
        cmp_shadow[sstc_pkg::REG_STIR_SECOND]   = sstc_pkg::RST_STIR_SECOND;
        for (int k = 0; k < 2*sstc_pkg::NUM_IR; k++) ir_count[k] = '0;
        for (int k = 0; k < sstc_pkg::NUM_SW; k++) gate_steps[k] = '0;
        ir_seen    = '0;
        gate_open  = '0;
        stir_ticks = '0;
        stir_phase = 1'b0;
        supplies   = '0;
        run_level  = 10'h3FF;
        for (int k = 0; k < 10; k++) run_left[k] = 0;
    endtask

    // ------------------------------------------------------------------------
    // Status predictor: advances the shadow by one tick and returns the
    // status word the controller must produce for it.
    // ------------------------------------------------------------------------
    function automatic sstc_pkg::t_out_word predict_tick_status(sstc_pkg::t_in_word tick);
        sstc_pkg::t_out_word status;
        logic       level;
        logic       pressed;
        logic [5:0] prev;
        logic [5:0] nxt;
        logic       out_full;
        logic       in_full;

        // IR qualifiers: lines 0..3 outside, 4..7 inside
        for (int k = 0; k < 2*sstc_pkg::NUM_IR; k++) begin
            level = (k < sstc_pkg::NUM_IR) ? tick.outside_sensors[k]
                                           : tick.inside_sensors[k-sstc_pkg::NUM_IR];
            if (ir_count[k] == 0) begin
                if (level) ir_count[k] = 2'd1;
            end else begin
                if (ir_count[k] < IR_CONFIRM) ir_count[k] = ir_count[k] + 2'd1;
                if (ir_count[k] >= IR_CONFIRM) begin
                    if (level) begin
                        ir_seen[k] = 1'b1;
                    end else begin
                        ir_seen[k]  = 1'b0;
                        ir_count[k] = '0;
                    end
                end
            end
        end

        // Switch / gate sequencers; a switch is pressed at level 0
        for (int ch = 0; ch < sstc_pkg::NUM_SW; ch++) begin
            pressed = !tick.switch_lines[ch];
            prev    = gate_steps[ch];
            if (prev == 0) begin
                if (pressed) gate_steps[ch] = 6'd1;
            end else begin
                nxt = (prev < GATE_CAP) ? prev + 6'd1 : prev;
                gate_steps[ch] = nxt;
                if (prev == PRESS_CONFIRM) begin
                    if (pressed) begin
                        supplies      = supplies + sstc_pkg::TOTAL_W'(1);
                        gate_open[ch] = 1'b1;
                    end else begin
                        gate_steps[ch] = '0;
                    end
                end else if (nxt == GATE_CLOSE_AT) begin
                    gate_open[ch] = 1'b0;
                end else if (!pressed && nxt > GATE_CLOSE_AT) begin
                    gate_steps[ch] = '0;
                end
            end
        end

        out_full = |ir_seen[sstc_pkg::NUM_IR-1:0];
        in_full  = |ir_seen[2*sstc_pkg::NUM_IR-1:sstc_pkg::NUM_IR];

        // Stirring runs only while the two sides are not both full
        if (!(out_full && in_full)) begin
            stir_ticks = stir_ticks + 6'd1;
            if (stir_ticks >= STIR_PERIOD) begin
                stir_ticks = '0;
                stir_phase = ~stir_phase;
            end
        end

        status.gate1_compare    = gate_open[0] ? cmp_shadow[sstc_pkg::REG_GATE1_OPEN]
                                               : cmp_shadow[sstc_pkg::REG_GATE1_CLOSED];
        status.gate2_compare    = gate_open[1] ? cmp_shadow[sstc_pkg::REG_GATE2_OPEN]
                                               : cmp_shadow[sstc_pkg::REG_GATE2_CLOSED];
        status.hopper_compare   = (out_full && in_full)
                                ? cmp_shadow[sstc_pkg::REG_HOPPER_CLOSED]
                                : cmp_shadow[sstc_pkg::REG_HOPPER_OPEN];
        status.stir_compare     = stir_phase ? cmp_shadow[sstc_pkg::REG_STIR_SECOND]
                                             : cmp_shadow[sstc_pkg::REG_STIR_FIRST];
        status.lamps            = gate_open;
        status.outside_full     = out_full;
        status.inside_full      = in_full;
        status.container_select = out_full;
        status.supply_count     = supplies;
        return status;
    endfunction

    function automatic void check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            if (error_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tick driver: offers queued words, with random gap bursts. A word is
    // only replaced once the block has taken it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= $urandom_range(0, 7);
            end else if (tick_queue.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= tick_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink stall: random bursts, plus one long hold-off on request, counted
    // here, that backs the block up into its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            i_out_stall    <= 1'b1;
            stall_left     <= LONG_HOLD;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every accepted tick word gets its prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_status.push_back(predict_tick_status(i_in_word));
    end

    // Every accepted status word is checked against the oldest prediction
    always @(posedge i_clk) begin
        sstc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: status word with no tick pending", $time);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("gate1_compare",    32'(o_out_word.gate1_compare),
                            32'(want.gate1_compare));
                check_field("gate2_compare",    32'(o_out_word.gate2_compare),
                            32'(want.gate2_compare));
                check_field("hopper_compare",   32'(o_out_word.hopper_compare),
                            32'(want.hopper_compare));
                check_field("stir_compare",     32'(o_out_word.stir_compare),
                            32'(want.stir_compare));
                check_field("lamps",            32'(o_out_word.lamps),
                            32'(want.lamps));
                check_field("outside_full",     32'(o_out_word.outside_full),
                            32'(want.outside_full));
                check_field("inside_full",      32'(o_out_word.inside_full),
                            32'(want.inside_full));
                check_field("container_select", 32'(o_out_word.container_select),
                            32'(want.container_select));
                check_field("supply_count",     o_out_word.supply_count,
                            want.supply_count);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("supply_station_tick_controller_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(logic [3:0] outside_lines, logic [3:0] inside_lines,
                             logic [1:0] switches, int repeats);
        sstc_pkg::t_in_word w;
        w.outside_sensors = outside_lines;
        w.inside_sensors  = inside_lines;
        w.switch_lines    = switches;
        for (int n = 0; n < repeats; n++) tick_queue.push_back(w);
    endtask

    // Mostly held levels with random content, about one word in twenty pure noise
    task automatic push_random_ticks(int count);
        sstc_pkg::t_in_word w;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                w = sstc_pkg::t_in_word'(10'($urandom_range(0, 1023)));
            end else begin
                for (int k = 0; k < 10; k++) begin
                    if (run_left[k] == 0) begin
                        run_level[k] = 1'($urandom_range(0, 1));
                        if (k < 8)
                            run_left[k] = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 14);
                        else if (run_level[k])
                            run_left[k] = $urandom_range(1, 20);  // released
                        else
                            run_left[k] = $urandom_range(1, 45);  // held
                    end
                    run_left[k]--;
                end
                w.outside_sensors = run_level[3:0];
                w.inside_sensors  = run_level[7:4];
                w.switch_lines    = run_level[9:8];
            end
            tick_queue.push_back(w);
        end
    endtask

    // Wait until every queued tick was taken and every status word checked
    task automatic wait_drained();
        @(negedge i_clk);
        while (tick_queue.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready; block must be idle
    task automatic write_setting(logic [sstc_pkg::CFG_IW-1:0] idx,
                                 logic [sstc_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cmp_shadow[idx] = value[sstc_pkg::CMP_W-1:0];
    endtask

    // mode 0: all zero, 1: all at range top, 2: every bit set, 3: random
    task automatic write_all_settings(int mode);
        logic [sstc_pkg::DATA_W-1:0] value;
        for (int r = 0; r < sstc_pkg::NUM_CFG; r++) begin
            case (mode)
                0: value = '0;
                1: value = 32'd8399;
                2: value = '1;
                default: value = ($urandom() & 32'hFFFF_C000) | $urandom_range(0, 8399);
            endcase
            write_setting(r[sstc_pkg::CFG_IW-1:0], value);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, register defaults: quiet tick, all lines qualify (both
        // sides full, hopper closed, stir frozen), inside drops out
        // (container two), both switches confirmed together, gates held
        // open after release, and more presses while the gates are still open
        push_tick(4'h0, 4'h0, 2'b11, 1);
        push_tick(4'hF, 4'hF, 2'b11, 4);
        push_tick(4'hF, 4'h0, 2'b11, 2);
        push_tick(4'h0, 4'h0, 2'b00, 5);
        push_tick(4'h0, 4'hF, 2'b11, 3);
        push_tick(4'h0, 4'h0, 2'b10, 4);
        push_tick(4'h0, 4'h0, 2'b11, 1);
        push_tick(4'h5, 4'hA, 2'b01, 2);
        push_tick(4'hA, 4'h5, 2'b10, 2);
        push_random_ticks(230);
        wait_drained();

        // All compares zero; the sink holds off long enough to back the
        // block up while ticks keep coming
        write_all_settings(0);
        push_random_ticks(250);
        long_hold_req = 1'b1;
        wait_drained();

        // Compares at the top of their range
        write_all_settings(1);
        push_random_ticks(250);
        wait_drained();

        // Every register bit set, upper bus bits must be dropped
        write_all_settings(2);
        push_random_ticks(250);
        wait_drained();

        write_all_settings(3);
        push_random_ticks(250);
        wait_drained();

        // Last stretch runs back to back with no gaps or stalls
        write_all_settings(3);
        idle_on = 1'b0;
        push_random_ticks(200);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_status.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("supply_station_tick_controller_tb: done, clean");
        end else begin
            $display("supply_station_tick_controller_tb: done, errors");
        end
        $finish;
    end

endmodule
